// File: design/peo_pkg.sv
// Shared types, constants and sine table arithmetic for the phase-entrained oscillator.
package peo_pkg;

  localparam int unsigned SineIndexBitsDef = 10;
  localparam int unsigned CfgIndexW        = 2;
  localparam longint unsigned HalfPiQ30    = 64'd1686629713;

  typedef enum logic {
    OpUpdate = 1'b0,
    OpInit   = 1'b1
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgNaturalFreq = 2'd0,
    CfgCouplingGain = 2'd1,
    CfgPhaseOffset = 2'd2,
    CfgTimeStep    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StLook,
    StMul,
    StRate,
    StStep,
    StLoad
  } peo_state_e;

  typedef struct packed {
    op_e                op;
    logic [31:0]        drive_phase;
    logic [31:0]        start_phase;
    logic signed [31:0] start_rate;
  } in_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [31:0] rate;
  } out_t;

  typedef struct packed {
    logic load_item;
    logic lookup;
    logic multiply;
    logic form_rate;
    logic commit_step;
    logic commit_load;
  } ctl_t;

  typedef struct packed {
    op_e op;
  } stat_t;

  function automatic longint unsigned taylor_next(input longint unsigned term,
                                                  input longint unsigned x);
    longint unsigned t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  function automatic logic [14:0] sine_entry(input int unsigned k,
                                             input int unsigned idx_bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    x    = (HalfPiQ30 * longint'(k)) >> idx_bits;
    term = x;
    sum  = longint'(x);
    term = taylor_next(term, x) / 6;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 20;
    sum  = sum + longint'(term);
    term = taylor_next(term, x) / 42;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 72;
    sum  = sum + longint'(term);
    term = taylor_next(term, x) / 110;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 16384) >> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return r[14:0];
  endfunction

endpackage

// File: design/peo_ctrl.sv
// Sequencing state machine and output valid flag for the phase-entrained oscillator.
module peo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  peo_pkg::stat_t stat_i,
  output peo_pkg::ctl_t  cmd_o
);
  import peo_pkg::*;

  peo_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       commit;

  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = cmd_o.commit_step || cmd_o.commit_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (stat_i.op == OpInit) ? StLoad : StLook;
        end
      end
      StLook: state_d = StMul;
      StMul:  state_d = StRate;
      StRate: state_d = StStep;
      StStep: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      StLoad: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      StLook: cmd_o.lookup = 1'b1;
      StMul:  cmd_o.multiply = 1'b1;
      StRate: cmd_o.form_rate = 1'b1;
      StStep: cmd_o.commit_step = out_free;
      StLoad: cmd_o.commit_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("Committed beat did not raise output valid.");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i))
    else $error("Result committed over an untaken beat.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StLook || state_q == StLoad))
    else $error("Accepted beat did not start work.");

endmodule

// File: design/peo_dpath.sv
// Datapath: configuration registers, oscillator state, sine ROM and arithmetic stages.
module peo_dpath #(
  parameter int unsigned SINE_INDEX_BITS = peo_pkg::SineIndexBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [peo_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  peo_pkg::in_t                    in_data_i,
  output peo_pkg::out_t                   out_data_o,
  input  peo_pkg::ctl_t                   cmd_i,
  output peo_pkg::stat_t                  stat_o
);
  import peo_pkg::*;

  localparam int unsigned AddrW     = SINE_INDEX_BITS + 1;
  localparam int unsigned SineDepth = (1 << SINE_INDEX_BITS) + 1;
  localparam logic [AddrW-1:0] Full = AddrW'(1) << SINE_INDEX_BITS;

  typedef logic [14:0] sine_rom_t [SineDepth];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SineDepth; k++) begin
      rom[k] = sine_entry(k, SINE_INDEX_BITS);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

  logic signed [31:0] natural_freq_q;
  logic signed [31:0] coupling_gain_q;
  logic [31:0]        phase_offset_q;
  logic [15:0]        time_step_q;
  logic [31:0]        cur_phase_q;
  logic signed [31:0] cur_rate_q;
  in_t                item_q;
  out_t               out_q;
  logic [14:0]        sine_mag_q;
  logic               sine_neg_q;
  logic signed [47:0] prod_q;

  logic [31:0]                err;
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [AddrW-1:0]           addr;
  logic signed [15:0]         sine_s;
  logic signed [47:0]         prod_d;
  logic signed [32:0]         corr;
  logic signed [33:0]         sum;
  logic signed [31:0]         rate_sat;
  logic [47:0]                delta;
  logic [31:0]                phase_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      natural_freq_q  <= '0;
      coupling_gain_q <= '0;
      phase_offset_q  <= '0;
      time_step_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgNaturalFreq:  natural_freq_q  <= cfg_data_i;
        CfgCouplingGain: coupling_gain_q <= cfg_data_i;
        CfgPhaseOffset:  phase_offset_q  <= cfg_data_i;
        CfgTimeStep:     time_step_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Phase error and quarter-wave folding of the table address.
  assign err  = item_q.drive_phase - cur_phase_q - phase_offset_q;
  assign idx  = err[29 -: SINE_INDEX_BITS];
  assign addr = err[30] ? (Full - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.lookup) begin
      sine_mag_q <= SineRom[addr];
      sine_neg_q <= err[31];
    end
    if (cmd_i.multiply) begin
      prod_q <= prod_d;
    end
  end

  assign sine_s = sine_neg_q ? -$signed({1'b0, sine_mag_q}) : $signed({1'b0, sine_mag_q});
  assign prod_d = coupling_gain_q * sine_s;

  // Floor division by 2^15 is an arithmetic shift; the sum then saturates to 32 bits.
  assign corr = prod_q[47:15];
  assign sum  = {{2{natural_freq_q[31]}}, natural_freq_q} + {corr[32], corr};

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      rate_sat = sum[31:0];
    end else if (sum[33]) begin
      rate_sat = 32'sh8000_0000;
    end else begin
      rate_sat = 32'sh7fff_ffff;
    end
  end

  assign delta      = 48'(unsigned'(cur_rate_q)) * 48'(time_step_q);
  assign phase_next = cur_phase_q + delta[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_phase_q <= '0;
      cur_rate_q  <= '0;
    end else begin
      if (cmd_i.commit_load) begin
        cur_phase_q <= item_q.start_phase;
        cur_rate_q  <= item_q.start_rate;
      end else if (cmd_i.commit_step) begin
        cur_phase_q <= phase_next;
      end else if (cmd_i.form_rate) begin
        cur_rate_q <= rate_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_load) begin
      out_q.phase <= item_q.start_phase;
      out_q.rate  <= item_q.start_rate;
    end else if (cmd_i.commit_step) begin
      out_q.phase <= phase_next;
      out_q.rate  <= cur_rate_q;
    end
  end

  assign out_data_o = out_q;
  assign stat_o.op  = in_data_i.op;

  a_load_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_load |=> cur_phase_q == $past(item_q.start_phase))
    else $error("Init beat did not load the start phase.");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_load || cmd_i.commit_step) |=>
      (out_q.phase == cur_phase_q && out_q.rate == cur_rate_q))
    else $error("Result beat differs from the oscillator state.");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit_load && cmd_i.commit_step))
    else $error("Both commit commands raised together.");

endmodule

// File: design/phase_entrained_oscillator.sv
// Top level of the phase-entrained oscillator: controller, datapath and port wiring.
// An update beat is accepted in the idle state and then passes through phase error with
// sine ROM read, gain multiply, rate sum with saturation, and phase step, each in a
// state of its own; an init beat goes from acceptance to a single load state. The
// next beat waits because its phase error needs the phase left by the previous one.
// A result waits in an output register, and a finished item stalls only while that
// register still holds an untaken beat. Configuration writes are taken in any cycle.
module phase_entrained_oscillator #(
  parameter int unsigned SINE_INDEX_BITS = peo_pkg::SineIndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [peo_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  peo_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output peo_pkg::out_t                 out_data_o
);
  import peo_pkg::*;

  ctl_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  peo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  peo_dpath #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
